[rtl/svs_pkg.sv]
`timescale 1ns / 1ps
// svs_pkg: constants, op codes and the command/status types shared by the
// Stokeslet velocity accumulator modules. No dependencies.
package svs_pkg;

	localparam int FRAC_BITS = 24;
	localparam int QW        = FRAC_BITS + 1;   // divider quotient width
	localparam int DEN_W     = 35;              // divisor width (widest divisor a = sq + e)
	localparam int NUM_W     = DEN_W + 1;       // dividend kept below 2 * divisor
	localparam int SUM_W     = 48;
	localparam int W_W       = 40;              // per-source term before scaling
	localparam int CFG_W     = 31;
	localparam int CFG_AW    = 1;
	localparam int NORM_TOP  = 34;              // MSB of the log argument register
	localparam int MA_W      = 35;
	localparam int MB_W      = 32;
	localparam int IN_W      = 192;
	localparam int OUT_W     = 64;

	localparam logic [CFG_W-1:0]  BLOB_RST  = 31'd383479;
	localparam logic [CFG_W-1:0]  SCALE_RST = 31'd1335088;
	localparam logic [29:0]       LN2_Q30   = 30'd744261118;
	localparam logic [QW-1:0]     ONE_Q     = QW'(1) << FRAC_BITS;
	localparam logic [SUM_W-1:0]  SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};

	localparam logic [CFG_AW-1:0] REG_BLOB  = 1'd0;
	localparam logic [CFG_AW-1:0] REG_SCALE = 1'd1;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_SQX, OP_SQY, OP_SQE, OP_ROOT, OP_FIX, OP_NORM,
		OP_LOGSQ, OP_LN, OP_DIV, OP_Q1, OP_DOT1, OP_DOT2, OP_T, OP_W1, OP_W2,
		OP_SC1, OP_SC2, OP_ACC, OP_OUT
	} op_t;

	typedef enum logic [2:0] {
		DS_RE, DS_RB, DS_UX, DS_UY, DS_VX, DS_VY
	} div_sel_t;

	typedef struct packed {
		op_t      op;
		logic     comp_y;
		logic     div_start;
		div_sel_t div_sel;
	} cmd_t;

	typedef struct packed {
		logic root_last;
		logic norm_done;
		logic log_last;
		logic div_done;
		logic last;
	} sts_t;

endpackage

[rtl/stokeslet_velocity_sum_core.sv]
`timescale 1ns / 1ps
// stokeslet_velocity_sum_core: top level of the 2D regularized Stokeslet
// velocity accumulator. Depends on svs_pkg, svs_ctrl, svs_dpath, svs_div.
//
//  channel   direction  handshake            payload
//  s_*       in         s_tvalid / s_tready  s_tdata (target, source, force), s_tlast
//  m_*       out        m_tvalid / m_tready  m_tdata (vel_x, vel_y), m_tuser (clipped)
//  cfg_*     in         cfg_we               cfg_addr, cfg_wdata
//
// Each source is stepped through in full before the next accept: the six
// divider runs set most of the time, then the 32-step square root, 24 log
// squarings and a normalizing shift on the log argument.
// arst_n clears the sums, the sequencer and the output valid, and loads the
// register defaults. A result waiting on m_tready stalls only the final
// source of the next run; all other sources go on being accepted.
module stokeslet_velocity_sum_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// target_x, target_y, source_x, source_y, force_x, force_y (32 each, low first)
	input  logic [svs_pkg::IN_W-1:0]    s_tdata,
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// vel_x [31:0], vel_y [63:32]
	output logic [svs_pkg::OUT_W-1:0]   m_tdata,
	// clipped [0]
	output logic [0:0]                  m_tuser,
	input  logic                        cfg_we,
	input  logic [svs_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [svs_pkg::CFG_W-1:0]   cfg_wdata
);
	import svs_pkg::*;

	cmd_t        cmd;
	sts_t        sts;
	logic [31:0] vel_x, vel_y;
	logic        clipped;

	// sequencer: one transaction in flight, steps the datapath op by op
	svs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: operand capture, arithmetic units, sums and result register
	svs_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_tdata),
		.in_last   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.clipped   (clipped)
	);

	// pack the held result for the master side
	assign m_tdata = {vel_y, vel_x};
	assign m_tuser = clipped;

endmodule

[rtl/svs_div.sv]
`timescale 1ns / 1ps
// svs_div: restoring divider, one quotient bit per cycle, for the ratios of
// the accumulator. Depends on svs_pkg.
module svs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [svs_pkg::NUM_W-1:0]  num,
	input  logic [svs_pkg::DEN_W-1:0]  den,
	output logic                       done,
	output logic [svs_pkg::QW-1:0]     quo
);
	import svs_pkg::*;

	logic              busy_q, done_q;
	logic [4:0]        cnt_q;
	logic [NUM_W-1:0]  r_q;
	logic [DEN_W-1:0]  den_q;
	logic [QW-1:0]     quo_q;
	logic              ge;
	logic [NUM_W-1:0]  rs;

	assign ge   = r_q >= NUM_W'(den_q);
	assign rs   = ge ? r_q - NUM_W'(den_q) : r_q;
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			r_q   <= {rs[NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

`ifndef ASSERT_OFF
	// partial remainder stays below twice the divisor, so the quotient fits
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start) |-> (r_q < {den_q, 1'b0}))
		else $error("divider remainder out of range");
`endif

endmodule

[rtl/svs_dpath.sv]
`timescale 1ns / 1ps
// svs_dpath: registers, shared multiplier, root/log iterations, divider and
// accumulators of the Stokeslet velocity sum. Depends on svs_pkg, svs_div.
module svs_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  svs_pkg::cmd_t               cmd,
	output svs_pkg::sts_t               sts,
	input  logic [svs_pkg::IN_W-1:0]    in_data,
	input  logic                        in_last,
	input  logic                        cfg_we,
	input  logic [svs_pkg::CFG_AW-1:0]  cfg_addr,
	input  logic [svs_pkg::CFG_W-1:0]   cfg_wdata,
	output logic [31:0]                 vel_x,
	output logic [31:0]                 vel_y,
	output logic                        clipped
);
	import svs_pkg::*;

	logic [CFG_W-1:0]  blob_q, scale_q, e_w;
	logic [32:0]       dx_q, dy_q;
	logic [31:0]       fx_q, fy_q;
	logic              last_q;
	logic [63:0]       s4_q, r_q, bit_q, rsum;
	logic [32:0]       sq_q, sq2, sqv;
	logic [33:0]       a_q, a_w;
	logic [34:0]       na_q;
	logic [5:0]        sh_q;
	logic [30:0]       m_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [4:0]        it_q;
	logic [30:0]       ln_q;
	logic [QW-1:0]     re_q, rb_q, ux_q, uy_q, vx_q, vy_q, quc;
	logic [31:0]       p1q_q;
	logic [33:0]       acc_q, dot_q;
	logic [34:0]       t_q;
	logic [W_W-1:0]    w_q;
	logic [30:0]       lo_q;
	logic [SUM_W-1:0]  c_q, sumx_q, sumy_q, cur_sum;
	logic [31:0]       velx_q, vely_q;
	logic              clip_q;

	logic [32:0]       adx, ady, adot;
	logic [31:0]       afx, afy, afc, ap1q;
	logic [34:0]       at;
	logic [W_W-1:0]    aw;
	logic [QW-1:0]     vc;
	logic              dsg;
	logic [6:0]        kk;
	logic [30:0]       lg, lgm;
	logic [MA_W-1:0]   ma;
	logic [MB_W-1:0]   mb;
	logic [MA_W+MB_W-1:0] prod;
	logic [31:0]       sqr;
	logic [32:0]       pr33;
	logic [33:0]       pr34;
	logic [34:0]       pr35;
	logic [36:0]       pr37;
	logic [SUM_W:0]    r49, acc49;
	logic [SUM_W-1:0]  r48;
	logic [NUM_W-1:0]  dnum, nmag, dlim;
	logic [DEN_W-1:0]  dden;
	logic              div_done;
	logic [QW-1:0]     quo;
	logic              satx, saty;

	assign e_w  = (blob_q == '0) ? CFG_W'(1) : blob_q;
	assign adx  = dx_q[32] ? 33'(-dx_q) : dx_q;
	assign ady  = dy_q[32] ? 33'(-dy_q) : dy_q;
	assign afx  = fx_q[31] ? -fx_q : fx_q;
	assign afy  = fy_q[31] ? -fy_q : fy_q;
	assign afc  = cmd.comp_y ? afy : afx;
	assign ap1q = p1q_q[31] ? -p1q_q : p1q_q;
	assign adot = 33'(dot_q[33] ? -dot_q : dot_q);
	assign at   = t_q[34] ? -t_q : t_q;
	assign aw   = w_q[W_W-1] ? -w_q : w_q;
	assign vc   = cmd.comp_y ? vy_q : vx_q;
	assign dsg  = cmd.comp_y ? dy_q[32] : dx_q[32];

	// log2 exponent and fraction side by side give the signed Q value
	assign kk  = 7'(NORM_TOP - FRAC_BITS) - 7'(sh_q);
	assign lg  = 31'({kk, frac_q});
	assign lgm = lg[30] ? -lg : lg;

	assign sq2 = {r_q[31:0], 1'b0};
	assign sqv = (sq2 < 33'(e_w)) ? 33'(e_w) : sq2;
	assign a_w = 34'(sqv) + 34'(e_w);
	assign rsum = r_q + bit_q;

	// one shared multiplier, operands picked by the op
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.op)
			OP_SQX:   begin ma = MA_W'(adx[31:0]); mb = adx[31:0]; end
			OP_SQY:   begin ma = MA_W'(ady[31:0]); mb = ady[31:0]; end
			OP_SQE:   begin ma = MA_W'(e_w); mb = MB_W'(e_w); end
			OP_LOGSQ: begin ma = MA_W'(m_q); mb = MB_W'(m_q); end
			OP_LN:    begin ma = MA_W'(lgm[29:0]); mb = MB_W'(LN2_Q30); end
			OP_Q1:    begin ma = MA_W'(re_q); mb = MB_W'(rb_q); end
			OP_DOT1:  begin ma = MA_W'(afx); mb = MB_W'(ux_q); end
			OP_DOT2:  begin ma = MA_W'(afy); mb = MB_W'(uy_q); end
			OP_T:     begin ma = MA_W'(adot); mb = MB_W'(rb_q); end
			OP_W1:    begin ma = MA_W'(at[33:0]); mb = MB_W'(vc); end
			OP_W2:    begin ma = MA_W'(afc); mb = MB_W'(ap1q[30:0]); end
			OP_SC1:   begin ma = MA_W'(aw[FRAC_BITS-1:0]); mb = MB_W'(scale_q); end
			OP_SC2:   begin ma = MA_W'(aw[W_W-2:FRAC_BITS]); mb = MB_W'(scale_q); end
			default:  begin ma = '0; mb = '0; end
		endcase
	end

	assign prod = {{MB_W{1'b0}}, ma} * {{MA_W{1'b0}}, mb};
	assign sqr  = prod[61:30];
	assign pr33 = prod[FRAC_BITS+32:FRAC_BITS];
	assign pr34 = prod[FRAC_BITS+33:FRAC_BITS];
	assign pr35 = prod[FRAC_BITS+34:FRAC_BITS];
	assign pr37 = prod[FRAC_BITS+36:FRAC_BITS];

	assign r49  = {1'b0, prod[SUM_W-1:0]} + (SUM_W+1)'(lo_q);
	assign r48  = (r49 > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : r49[SUM_W-1:0];

	assign cur_sum = cmd.comp_y ? sumy_q : sumx_q;
	assign acc49   = {cur_sum[SUM_W-1], cur_sum} + {c_q[SUM_W-1], c_q};

	// divider operands; clip the dividend to 2*den-1 so the quotient stays below
	// two; the ux, uy, vx and vy ratios are then clamped to one
	always_comb begin
		nmag = '0;
		dden = '0;
		unique case (cmd.div_sel)
			DS_RE:   begin nmag = NUM_W'(e_w);   dden = DEN_W'(sq_q); end
			DS_RB:   begin nmag = NUM_W'(a_q) + NUM_W'(e_w); dden = DEN_W'(a_q); end
			DS_UX:   begin nmag = NUM_W'(adx);   dden = DEN_W'(a_q); end
			DS_UY:   begin nmag = NUM_W'(ady);   dden = DEN_W'(a_q); end
			DS_VX:   begin nmag = NUM_W'(adx);   dden = DEN_W'(sq_q); end
			DS_VY:   begin nmag = NUM_W'(ady);   dden = DEN_W'(sq_q); end
			default: begin nmag = '0;            dden = DEN_W'(1); end
		endcase
	end

	assign dlim = {dden, 1'b0} - NUM_W'(1);
	assign dnum = (nmag > dlim) ? dlim : nmag;
	assign quc  = (quo > ONE_Q) ? ONE_Q : quo;

	svs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dnum),
		.den    (dden),
		.done   (div_done),
		.quo    (quo)
	);

	assign satx = (sumx_q[SUM_W-1:31] != '0) && (sumx_q[SUM_W-1:31] != '1);
	assign saty = (sumy_q[SUM_W-1:31] != '0) && (sumy_q[SUM_W-1:31] != '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blob_q  <= BLOB_RST;
			scale_q <= SCALE_RST;
			sumx_q  <= '0;
			sumy_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_BLOB:  blob_q  <= cfg_wdata;
					REG_SCALE: scale_q <= cfg_wdata;
				endcase
			end
			if (cmd.op == OP_ACC) begin
				if (acc49[SUM_W] != acc49[SUM_W-1]) begin
					if (cmd.comp_y)
						sumy_q <= acc49[SUM_W] ? ~SUM_MAX : SUM_MAX;
					else
						sumx_q <= acc49[SUM_W] ? ~SUM_MAX : SUM_MAX;
				end else if (cmd.comp_y) begin
					sumy_q <= acc49[SUM_W-1:0];
				end else begin
					sumx_q <= acc49[SUM_W-1:0];
				end
			end else if (cmd.op == OP_OUT) begin
				sumx_q <= '0;
				sumy_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				dx_q   <= {in_data[31], in_data[31:0]} - {in_data[95], in_data[95:64]};
				dy_q   <= {in_data[63], in_data[63:32]} - {in_data[127], in_data[127:96]};
				fx_q   <= in_data[159:128];
				fy_q   <= in_data[191:160];
				last_q <= in_last;
			end
			OP_SQX: s4_q <= {2'b0, prod[63:2]};
			OP_SQY: s4_q <= s4_q + {2'b0, prod[63:2]};
			OP_SQE: begin
				s4_q  <= s4_q + {2'b0, prod[63:2]};
				r_q   <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_ROOT: begin
				if (s4_q >= rsum) begin
					s4_q <= s4_q - rsum;
					r_q  <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_FIX: begin
				sq_q <= sqv;
				a_q  <= a_w;
				na_q <= 35'(a_w);
				sh_q <= '0;
			end
			OP_NORM: begin
				if (!na_q[NORM_TOP]) begin
					na_q <= {na_q[NORM_TOP-1:0], 1'b0};
					sh_q <= sh_q + 6'd1;
				end else begin
					m_q    <= na_q[NORM_TOP:NORM_TOP-30];
					frac_q <= '0;
					it_q   <= '0;
				end
			end
			OP_LOGSQ: begin
				// square the mantissa; a carry past 2 yields a fraction bit
				if (sqr[31]) begin
					m_q    <= sqr[31:1];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
				end else begin
					m_q    <= sqr[30:0];
					frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
				end
				it_q <= it_q + 5'd1;
			end
			OP_LN: ln_q <= lg[30] ? -{1'b0, prod[59:30]} : {1'b0, prod[59:30]};
			OP_DIV: begin
				if (div_done) begin
					unique case (cmd.div_sel)
						DS_RE:   re_q <= quo;
						DS_RB:   rb_q <= quo;
						DS_UX:   ux_q <= quc;
						DS_UY:   uy_q <= quc;
						DS_VX:   vx_q <= quc;
						DS_VY:   vy_q <= quc;
						default: ;
					endcase
				end
			end
			OP_Q1: p1q_q <= {ln_q[30], ln_q} - 32'(prod[FRAC_BITS+25:FRAC_BITS]);
			OP_DOT1: acc_q <= (dx_q[32] ^ fx_q[31]) ? -34'(pr33) : 34'(pr33);
			OP_DOT2: dot_q <= acc_q + ((dy_q[32] ^ fy_q[31]) ? -34'(pr33) : 34'(pr33));
			OP_T:    t_q   <= dot_q[33] ? -35'(pr34) : 35'(pr34);
			OP_W1:   w_q   <= (dsg ^ t_q[34]) ? -W_W'(pr35) : W_W'(pr35);
			OP_W2: begin
				if (p1q_q[31] ^ (cmd.comp_y ? fy_q[31] : fx_q[31]))
					w_q <= w_q + W_W'(pr37);
				else
					w_q <= w_q - W_W'(pr37);
			end
			OP_SC1: lo_q <= prod[FRAC_BITS+30:FRAC_BITS];
			OP_SC2: c_q  <= w_q[W_W-1] ? -r48 : r48;
			OP_OUT: begin
				velx_q <= satx ? (sumx_q[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
				               : sumx_q[31:0];
				vely_q <= saty ? (sumy_q[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
				               : sumy_q[31:0];
				clip_q <= satx | saty;
			end
			default: ;
		endcase
	end

	assign sts.root_last = bit_q[0];
	assign sts.norm_done = na_q[NORM_TOP];
	assign sts.log_last  = (it_q == 5'(FRAC_BITS - 1));
	assign sts.div_done  = div_done;
	assign sts.last      = last_q;

	assign vel_x   = velx_q;
	assign vel_y   = vely_q;
	assign clipped = clip_q;

`ifndef ASSERT_OFF
	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_ROOT) |-> $onehot(bit_q))
		else $error("root step bit lost");
	a_log_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_LOGSQ) |-> m_q[30])
		else $error("log mantissa not normalized");
`endif

endmodule

[rtl/svs_ctrl.sv]
`timescale 1ns / 1ps
// svs_ctrl: sequencer that steps the datapath through one source item and
// owns the input ready and output valid. Depends on svs_pkg.
module svs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  svs_pkg::sts_t  sts,
	output svs_pkg::cmd_t  cmd
);
	import svs_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_SQX   = 5'd1;
	localparam logic [4:0] S_SQY   = 5'd2;
	localparam logic [4:0] S_SQE   = 5'd3;
	localparam logic [4:0] S_ROOT  = 5'd4;
	localparam logic [4:0] S_FIX   = 5'd5;
	localparam logic [4:0] S_NORM  = 5'd6;
	localparam logic [4:0] S_LOGSQ = 5'd7;
	localparam logic [4:0] S_LN    = 5'd8;
	localparam logic [4:0] S_DIVGO = 5'd9;
	localparam logic [4:0] S_DIVWT = 5'd10;
	localparam logic [4:0] S_Q1    = 5'd11;
	localparam logic [4:0] S_DOT1  = 5'd12;
	localparam logic [4:0] S_DOT2  = 5'd13;
	localparam logic [4:0] S_T     = 5'd14;
	localparam logic [4:0] S_W1    = 5'd15;
	localparam logic [4:0] S_W2    = 5'd16;
	localparam logic [4:0] S_SC1   = 5'd17;
	localparam logic [4:0] S_SC2   = 5'd18;
	localparam logic [4:0] S_ACC   = 5'd19;
	localparam logic [4:0] S_DONE  = 5'd20;

	logic [4:0] state_q, state_d;
	div_sel_t   sel_q, sel_d;
	logic       comp_q, comp_d;
	logic       ovalid_q;
	logic       accept, room;

	function automatic div_sel_t next_sel(input div_sel_t s);
		unique case (s)
			DS_RE:   next_sel = DS_RB;
			DS_RB:   next_sel = DS_UX;
			DS_UX:   next_sel = DS_UY;
			DS_UY:   next_sel = DS_VX;
			DS_VX:   next_sel = DS_VY;
			default: next_sel = DS_RE;
		endcase
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign room     = !ovalid_q || m_tready;
	assign m_tvalid = ovalid_q;

	always_comb begin
		cmd     = '{op: OP_NOP, comp_y: comp_q, div_start: 1'b0, div_sel: sel_q};
		state_d = state_q;
		sel_d   = sel_q;
		comp_d  = comp_q;
		unique case (state_q)
			S_IDLE: if (accept) begin
				cmd.op  = OP_LOAD;
				state_d = S_SQX;
			end
			S_SQX: begin cmd.op = OP_SQX; state_d = S_SQY; end
			S_SQY: begin cmd.op = OP_SQY; state_d = S_SQE; end
			S_SQE: begin cmd.op = OP_SQE; state_d = S_ROOT; end
			S_ROOT: begin
				cmd.op = OP_ROOT;
				if (sts.root_last)
					state_d = S_FIX;
			end
			S_FIX: begin cmd.op = OP_FIX; state_d = S_NORM; end
			S_NORM: begin
				cmd.op = OP_NORM;
				if (sts.norm_done)
					state_d = S_LOGSQ;
			end
			S_LOGSQ: begin
				cmd.op = OP_LOGSQ;
				if (sts.log_last)
					state_d = S_LN;
			end
			S_LN: begin
				cmd.op  = OP_LN;
				sel_d   = DS_RE;
				state_d = S_DIVGO;
			end
			S_DIVGO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVWT;
			end
			S_DIVWT: begin
				cmd.op = OP_DIV;
				if (sts.div_done) begin
					sel_d   = next_sel(sel_q);
					state_d = (sel_q == DS_VY) ? S_Q1 : S_DIVGO;
				end
			end
			S_Q1:   begin cmd.op = OP_Q1; state_d = S_DOT1; end
			S_DOT1: begin cmd.op = OP_DOT1; state_d = S_DOT2; end
			S_DOT2: begin cmd.op = OP_DOT2; state_d = S_T; end
			S_T: begin
				cmd.op  = OP_T;
				comp_d  = 1'b0;
				state_d = S_W1;
			end
			S_W1:  begin cmd.op = OP_W1; state_d = S_W2; end
			S_W2:  begin cmd.op = OP_W2; state_d = S_SC1; end
			S_SC1: begin cmd.op = OP_SC1; state_d = S_SC2; end
			S_SC2: begin cmd.op = OP_SC2; state_d = S_ACC; end
			S_ACC: begin
				cmd.op = OP_ACC;
				if (comp_q) begin
					state_d = S_DONE;
				end else begin
					comp_d  = 1'b1;
					state_d = S_W1;
				end
			end
			S_DONE: begin
				// final source: hold here while a finished result still occupies the output; others return to idle
				if (!sts.last) begin
					state_d = S_IDLE;
				end else if (room) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sel_q    <= DS_RE;
			comp_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			comp_q  <= comp_d;
			if (cmd.op == OP_OUT)
				ovalid_q <= 1'b1;
			else if (m_tready)
				ovalid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT) |-> (!ovalid_q || m_tready))
		else $error("result overwritten before it was taken");
`endif

endmodule
